@@ design/multi_queue_priority_select_macros.svh @@
// Assertion macros used by the request sequencer of the multi-queue priority select RTL.
`ifndef MULTI_QUEUE_PRIORITY_SELECT_MACROS_SVH
`define MULTI_QUEUE_PRIORITY_SELECT_MACROS_SVH
`ifndef SYNTHESIS
`define MQPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MQPS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MQPS_ASSERT(label, clk, rst, prop, msg)
`define MQPS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ design/mqps_pkg.sv @@
// Types and constants of the multi-queue priority select block.
`default_nettype none
package mqps_pkg;
   localparam int ID_W     = 32;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 3;
   localparam int QSEL_W   = 2;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXTRACTED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd4;

   localparam logic REQ_INSERT  = 1'b0;
   localparam logic REQ_EXTRACT = 1'b1;

   localparam logic [ID_W-1:0] ARRIVAL_FIRST = 32'd1;
   localparam logic [ID_W-1:0] ARRIVAL_MAX   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic              req_type;
      logic [QSEL_W-1:0] queue_sel;
      logic [PRIO_W-1:0] priority_req;
   } mqps_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     served_id;
   } mqps_rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } mqps_entry_type;

   typedef struct packed {
      logic         valid;
      mqps_rsp_type rsp;
   } mqps_result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } mqps_state_type;
endpackage
`default_nettype wire

@@ design/multi_queue_priority_select.sv @@
// Top level of the multi-queue priority select block.
`default_nettype none
// NUM_QUEUES priority queues of QUEUE_DEPTH entries each share one entry memory
// and one arrival counter that starts at 1 and saturates. An extract scans the
// queue through the single read port of the entry memory, one slot per cycle,
// and then moves the entries behind the winner down one slot per cycle. One item
// is worked on at a time; a finished result waits in the output register while
// the next item is taken.
module multi_queue_priority_select #(
   parameter int NUM_QUEUES  = 3,
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire mqps_pkg::mqps_req_type req_item,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output mqps_pkg::mqps_rsp_type   rsp_item
);
   import mqps_pkg::*;

   localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W  = $clog2(ENTRIES);

   logic              busy;
   mqps_result_type   result;
   logic              out_space;
   logic              load;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   mqps_entry_type    ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   mqps_entry_type    ram_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   mqps_rsp_type      rsp_item_ff, rsp_item_in;

   mqps_entry_ram #(
      .DEPTH  (ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mqps_engine #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_item    (req_item),
      .busy        (busy),
      .result      (result),
      .out_ready   (out_space),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // The output register frees up in the same cycle that its item is taken.
   assign out_space = !rsp_valid_ff || !rsp_stall;
   assign load      = result.valid && out_space;

   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_item_in  = load ? result.rsp : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
endmodule
`default_nettype wire

@@ design/mqps_entry_ram.sv @@
// Entry memory: one write port and one registered read port.
`default_nettype none
module mqps_entry_ram #(
   parameter int DEPTH  = 48,
   parameter int ADDR_W = 6
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [ADDR_W-1:0]       wr_addr,
   input  wire mqps_pkg::mqps_entry_type wr_data,
   input  wire logic                    rd_en,
   input  wire logic [ADDR_W-1:0]       rd_addr,
   output mqps_pkg::mqps_entry_type     rd_data
);
   import mqps_pkg::*;

   mqps_entry_type entry_mem_ff [DEPTH];
   mqps_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ design/mqps_engine.sv @@
// Request sequencer: queue counts, arrival counter, scan and compaction of one queue.
`default_nettype none
`include "multi_queue_priority_select_macros.svh"
module mqps_engine #(
   parameter int NUM_QUEUES  = 3,
   parameter int QUEUE_DEPTH = 16,
   parameter int ADDR_W      = 6
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire mqps_pkg::mqps_req_type  req_item,
   output logic                         busy,
   output mqps_pkg::mqps_result_type    result,
   input  wire logic                    out_ready,
   output logic                         ram_wr_en,
   output logic [ADDR_W-1:0]            ram_wr_addr,
   output mqps_pkg::mqps_entry_type     ram_wr_data,
   output logic                         ram_rd_en,
   output logic [ADDR_W-1:0]            ram_rd_addr,
   input  wire mqps_pkg::mqps_entry_type ram_rd_data
);
   import mqps_pkg::*;

   localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CNT_X  = CNT_W + 1;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [QIDX_W-1:0] q,
                                                   input logic [CNT_W-1:0] slot);
      slot_addr = ADDR_W'(32'(q) * QUEUE_DEPTH + 32'(slot));
   endfunction

   // True when entry a is served before entry b.
   function automatic logic beats(input mqps_entry_type a, input mqps_entry_type b);
      beats = (a.prio > b.prio) || ((a.prio == b.prio) && (a.id < b.id));
   endfunction

   mqps_state_type    state_ff, state_in;
   logic [QIDX_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  rd_slot_ff, rd_slot_in;
   logic [SLOT_W-1:0] cmp_slot_ff, cmp_slot_in;
   logic [SLOT_W-1:0] best_slot_ff, best_slot_in;
   mqps_entry_type    best_ff, best_in;
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   mqps_rsp_type      res_ff, res_in;
   logic [ID_W-1:0]   arrival_ff, arrival_in;
   logic [CNT_W-1:0]  count_ff [NUM_QUEUES];

   logic              count_we;
   logic [QIDX_W-1:0] count_wq;
   logic [CNT_W-1:0]  count_wval;

   logic              accept;
   logic              q_valid;
   logic [QIDX_W-1:0] q_idx;
   logic [CNT_W-1:0]  cur_count;
   logic              take;
   logic [SLOT_W-1:0] best_slot_next;
   mqps_entry_type    best_next;
   logic              scan_last;
   logic              need_shift;
   logic              shift_more;

   assign accept  = req_valid && (state_ff == ST_IDLE);
   assign q_valid = 32'(req_item.queue_sel) < NUM_QUEUES;
   assign q_idx   = QIDX_W'(req_item.queue_sel);
   assign cur_count = q_valid ? count_ff[q_idx] : '0;

   // The first entry of a scan is taken as the best unconditionally.
   assign take           = (cmp_slot_ff == '0) || beats(ram_rd_data, best_ff);
   assign best_slot_next = take ? cmp_slot_ff : best_slot_ff;
   assign best_next      = take ? ram_rd_data : best_ff;
   assign scan_last      = CNT_W'(cmp_slot_ff) == (n_ff - CNT_W'(1));
   assign need_shift     = CNT_W'(best_slot_next) != (n_ff - CNT_W'(1));
   assign shift_more     = (CNT_X'(wr_slot_ff) + CNT_X'(2)) < CNT_X'(n_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (q_valid && (req_item.req_type == REQ_EXTRACT) && (cur_count != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = need_shift ? ST_SHIFT : ST_RESP;
            end
         end
         ST_SHIFT: begin
            if (!shift_more) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_addr(q_ff, CNT_W'(wr_slot_ff));
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = slot_addr(q_ff, rd_slot_ff);
      q_in         = q_ff;
      n_in         = n_ff;
      rd_slot_in   = rd_slot_ff;
      cmp_slot_in  = cmp_slot_ff;
      best_slot_in = best_slot_ff;
      best_in      = best_ff;
      wr_slot_in   = wr_slot_ff;
      res_in       = res_ff;
      arrival_in   = arrival_ff;
      count_we     = 1'b0;
      count_wq     = q_ff;
      count_wval   = n_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               q_in             = q_idx;
               n_in             = cur_count;
               res_in.served_id = '0;
               if (!q_valid) begin
                  res_in.status = STATUS_INVALID;
               end else if (req_item.req_type == REQ_INSERT) begin
                  if (cur_count == CNT_W'(QUEUE_DEPTH)) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     ram_wr_en        = 1'b1;
                     ram_wr_addr      = slot_addr(q_idx, cur_count);
                     ram_wr_data.id   = arrival_ff;
                     ram_wr_data.prio = req_item.priority_req;
                     count_we         = 1'b1;
                     count_wq         = q_idx;
                     count_wval       = cur_count + CNT_W'(1);
                     if (arrival_ff != ARRIVAL_MAX) begin
                        arrival_in = arrival_ff + ID_W'(1);
                     end
                     res_in.status = STATUS_INSERTED;
                  end
               end else if (cur_count == '0) begin
                  res_in.status = STATUS_EMPTY;
               end else begin
                  ram_rd_en     = 1'b1;
                  ram_rd_addr   = slot_addr(q_idx, '0);
                  rd_slot_in    = CNT_W'(1);
                  cmp_slot_in   = '0;
                  res_in.status = STATUS_EXTRACTED;
               end
            end
         end
         ST_SCAN: begin
            best_slot_in = best_slot_next;
            best_in      = best_next;
            cmp_slot_in  = cmp_slot_ff + SLOT_W'(1);
            if (rd_slot_ff < n_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = slot_addr(q_ff, rd_slot_ff);
               rd_slot_in  = rd_slot_ff + CNT_W'(1);
            end
            if (scan_last) begin
               res_in.status    = STATUS_EXTRACTED;
               res_in.served_id = best_next.id;
               count_we         = 1'b1;
               count_wval       = n_ff - CNT_W'(1);
               // Start pulling the entries behind the winner down by one slot.
               if (need_shift) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = slot_addr(q_ff, CNT_W'(best_slot_next) + CNT_W'(1));
                  wr_slot_in  = best_slot_next;
               end
            end
         end
         ST_SHIFT: begin
            // Data read last cycle belongs to the slot above the one written now.
            ram_wr_en = 1'b1;
            if (shift_more) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = slot_addr(q_ff, CNT_W'(wr_slot_ff) + CNT_W'(2));
               wr_slot_in  = wr_slot_ff + SLOT_W'(1);
            end
         end
         ST_RESP: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         arrival_ff <= ARRIVAL_FIRST;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         arrival_ff <= arrival_in;
         if (count_we) begin
            count_ff[count_wq] <= count_wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff         <= q_in;
      n_ff         <= n_in;
      rd_slot_ff   <= rd_slot_in;
      cmp_slot_ff  <= cmp_slot_in;
      best_slot_ff <= best_slot_in;
      best_ff      <= best_in;
      wr_slot_ff   <= wr_slot_in;
      res_ff       <= res_in;
   end

   assign busy         = state_ff != ST_IDLE;
   assign result.valid = state_ff == ST_RESP;
   assign result.rsp   = res_ff;

   `MQPS_ASSERT(a_arrival_nonzero, clock, reset, arrival_ff != '0, "arrival counter is zero")
   `MQPS_ASSERT(a_arrival_grows, clock, reset, !$past(reset) |-> arrival_ff >= $past(arrival_ff), "arrival counter went back")
   `MQPS_ASSERT(a_no_port_clash, clock, reset, ram_rd_en && ram_wr_en |-> ram_rd_addr != ram_wr_addr, "read and write hit one entry")
   `MQPS_ASSERT(a_served_nonzero, clock, reset, result.valid && (res_ff.status == STATUS_EXTRACTED) |-> res_ff.served_id != '0, "extracted item has no arrival number")
   `MQPS_ASSERT_ALWAYS(a_reset_state, clock, $past(reset) && !reset |-> (state_ff == ST_IDLE) && (arrival_ff == ARRIVAL_FIRST), "reset did not restore state")
endmodule
`default_nettype wire
